// File: hdl/lpim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_pkg: shared types and constants of the linear probe id map
// Command and status codes, field widths and the response word format.
// ----------------------------------------------------------------------------
package lpim_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 8;

    // Default bucket count
    localparam int BUCKETS_DEF = 256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Response word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    slot_number;
        logic [OUT_W-1:0]    entry_count;
    } rsp_word_t;

endpackage

// File: hdl/lpim_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_if: valid/ready channels of the linear probe id map
// Request channel (command, type_id) and response channel (status,
// slot_number, entry_count). A word moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface lpim_cmd_if
    import lpim_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] type_id;

    modport source (output valid, output command, output type_id, input ready);
    modport sink   (input valid, input command, input type_id, output ready);
endinterface

interface lpim_rsp_if
    import lpim_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    slot_number;
    logic [OUT_W-1:0]    entry_count;

    modport source (output valid, output status, output slot_number,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input slot_number,
                    input entry_count, output ready);
endinterface

// File: hdl/lpim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lpim_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_core: probe sequencer of the linear probe id map
// Computes the home bucket, walks the bucket RAM one bucket per cycle with
// a shared compare/increment unit, inserts on a free bucket and sweeps the
// RAM on clear and after reset.
// ----------------------------------------------------------------------------
module lpim_core
    import lpim_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lpim_cmd_if.sink  request,
    output logic      res_valid,
    input  logic      res_ready,
    output rsp_word_t res_word
);

    localparam int  IDX_W    = $clog2(BUCKETS);
    localparam int  LIMIT    = (3 * BUCKETS) / 4;
    localparam int  CNT_W    = $clog2(LIMIT + 1);
    localparam int  RAM_W    = 1 + CNT_W + KEY_W;
    localparam bit  IS_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

    // Reciprocal of the bucket count for the home-bucket remainder
    localparam logic [2*KEY_W-1:0] RECIP_NUM  = (2*KEY_W)'((2 ** IDX_W) - BUCKETS) << KEY_W;
    localparam logic [2*KEY_W-1:0] RECIP_WIDE = RECIP_NUM / (2*KEY_W)'(BUCKETS) + 1'b1;
    localparam logic [KEY_W-1:0]   RECIP_M    = RECIP_WIDE[KEY_W-1:0];
    localparam logic [IDX_W-1:0]   B_LOW      = IDX_W'(BUCKETS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_CMP,
        S_CLR,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [KEY_W-1:0] div_reg, div_next;
    logic [1:0]       step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsp_word_t        res_reg, res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    logic               rd_used;
    logic [CNT_W-1:0]   rd_slot;
    logic [KEY_W-1:0]   rd_key;
    logic [IDX_W-1:0]   idx_inc;
    logic [2*KEY_W-1:0] recip_prod;
    logic [KEY_W-1:0]   quo_calc;
    logic [IDX_W-1:0]   rem_calc;

    // Count or slot to the 8-bit output field
    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    // Bucket word: used bit, dense slot, key
    lpim_ram #(
        .WIDTH (RAM_W),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_used = ram_rdata[RAM_W-1];
    assign rd_slot = ram_rdata[KEY_W +: CNT_W];
    assign rd_key  = ram_rdata[KEY_W-1:0];

    // Shared bucket increment with wrap
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Remainder by a bucket count that is not a power of two:
    // high word of key * reciprocal, quotient fixup, then key - q * BUCKETS
    assign recip_prod = (2*KEY_W)'(key_reg) * (2*KEY_W)'(RECIP_M);
    assign quo_calc   = (div_reg + ((key_reg - div_reg) >> 1)) >> (IDX_W - 1);
    assign rem_calc   = key_reg[IDX_W-1:0] - div_reg[IDX_W-1:0] * B_LOW;

    assign request.ready = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res_word      = res_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        probe_next = probe_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = '0;
        ram_raddr  = idx_inc;

        case (state_reg)
            S_INIT, S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    cnt_next = '0;
                    res_next = '{status: ST_FOUND, slot_number: '0, entry_count: '0};
                    state_next = (state_reg == S_CLR) ? S_DONE : S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next  = request.command;
                    key_next  = request.type_id;
                    step_next = '0;
                    if (request.command == CMD_CLEAR)
                    begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else if (request.command == CMD_LOOKUP ||
                             request.command == CMD_INSERT)
                    begin
                        if (request.type_id == '0)
                        begin
                            res_next = '{status: ST_INVALID, slot_number: '0,
                                         entry_count: to_out(cnt_reg)};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                    else
                    begin
                        res_next = '{status: ST_ABSENT, slot_number: '0,
                                     entry_count: to_out(cnt_reg)};
                        state_next = S_DONE;
                    end
                end
            end

            // Home bucket, then first read
            S_MOD:
            begin
                probe_next = '0;
                if (IS_POW2)
                begin
                    ram_raddr  = key_reg[IDX_W-1:0];
                    idx_next   = key_reg[IDX_W-1:0];
                    state_next = S_CMP;
                end
                else if (step_reg == 2'd0)
                begin
                    div_next  = recip_prod[2*KEY_W-1:KEY_W];
                    step_next = 2'd1;
                end
                else if (step_reg == 2'd1)
                begin
                    div_next  = quo_calc;
                    step_next = 2'd2;
                end
                else
                begin
                    ram_raddr  = rem_calc;
                    idx_next   = rem_calc;
                    state_next = S_CMP;
                end
            end

            // One bucket per cycle; next bucket is read ahead
            S_CMP:
            begin
                if (!rd_used)
                begin
                    state_next = S_DONE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_next = '{status: ST_ABSENT, slot_number: '0,
                                     entry_count: to_out(cnt_reg)};
                    end
                    else if (32'(cnt_reg) >= 32'(LIMIT))
                    begin
                        res_next = '{status: ST_FULL, slot_number: '0,
                                     entry_count: to_out(cnt_reg)};
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = {1'b1, cnt_reg, key_reg};
                        cnt_next  = cnt_reg + 1'b1;
                        res_next  = '{status: ST_INSERTED, slot_number: to_out(cnt_reg),
                                      entry_count: to_out(cnt_reg + 1'b1)};
                    end
                end
                else if (rd_key == key_reg)
                begin
                    res_next = '{status: ST_FOUND, slot_number: to_out(rd_slot),
                                 entry_count: to_out(cnt_reg)};
                    state_next = S_DONE;
                end
                else if (probe_reg == LAST_IDX)
                begin
                    res_next = '{status: (cmd_reg == CMD_LOOKUP) ? ST_ABSENT : ST_FULL,
                                 slot_number: '0, entry_count: to_out(cnt_reg)};
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        probe_reg <= probe_next;
        div_reg   <= div_next;
        step_reg  <= step_next;
        res_reg   <= res_next;
    end

    // Count never passes the load limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(LIMIT))
        else $error("entry count above load limit");

    // An insert write raises the count by one
    a_insert_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && ram_we) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("insert did not advance the count");

    // RAM is written only by the sweep or an insert
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CMP || state_reg == S_CLR || state_reg == S_INIT))
        else $error("bucket write outside sweep or insert");

    // Slot is zero unless found or inserted
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.status != ST_FOUND && res_word.status != ST_INSERTED)
        |-> (res_word.slot_number == '0))
        else $error("nonzero slot on a miss");

    // A cleared table answers with count zero
    a_clear_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && state_next == S_DONE) |=> (cnt_reg == '0))
        else $error("count not zero after clear");

endmodule

// File: hdl/linear_probe_id_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_id_map: open-addressing id map with linear probing
// Maps nonzero 32-bit identifiers to dense slot numbers; lookup,
// insert-or-find and clear. Fixed table, table-full status at 3/4 load.
// ----------------------------------------------------------------------------
//  channel   | dir | fields                                 | moves when
//  request   | in  | command[1:0], type_id[31:0]            | valid && ready
//  response  | out | status[2:0], slot_number[7:0],         | valid && ready
//            |     | entry_count[7:0]                       |
//
//  Lookup/insert: buckets are probed one per cycle through the bucket RAM
//  read port, starting at the home bucket; with a bucket count that is not a
//  power of two the home bucket comes from a reciprocal-multiply remainder.
//  Clear: one bucket cleared per cycle, over all BUCKETS buckets.
//  Invalid id or unused command: answered without a bucket read.
//  After reset a clearing pass over all buckets runs before the first word.
//  The response register holds a result while the next request is worked.
// ----------------------------------------------------------------------------
module linear_probe_id_map
    import lpim_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lpim_cmd_if.sink    request,
    lpim_rsp_if.source  response
);

    logic      res_valid;
    logic      res_ready;
    rsp_word_t res_word;
    logic      out_valid_reg, out_valid_next;
    rsp_word_t out_word_reg, out_word_next;

    lpim_core #(
        .BUCKETS (BUCKETS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // Output register
    assign res_ready = !out_valid_reg || response.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_word_next = res_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_word_reg.status;
    assign response.slot_number = out_word_reg.slot_number;
    assign response.entry_count = out_word_reg.entry_count;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the linear probe id map
// A directed table covers reset, invalid ids, probe wrap-around, clear and the
// unused command. Random phases follow, each opened by a clear, with sparse
// and dense fills up to the load limit. Every accepted request is run through
// a behavioral copy of the map, and each response word is checked field by
// field in arrival order. Both channels idle at random, with one quiet phase.
// ----------------------------------------------------------------------------
module tb_top;
    import lpim_pkg::*;

    localparam int BUCKETS = BUCKETS_DEF;
    localparam int DIR_ROWS = 21;
    localparam int PHASES = 8;
    localparam int IDLE_PCT = 31;
    localparam int DRAIN_CYCLES = BUCKETS + 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Directed row: request plus an optional typed-in response
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] id;
        logic             has_fixed;
        rsp_word_t        fixed;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic quiet;

    lpim_cmd_if request_ch ();
    lpim_rsp_if response_ch ();

    linear_probe_id_map #(
        .BUCKETS (BUCKETS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_key  [BUCKETS];
    logic             shadow_used [BUCKETS];
    logic [OUT_W-1:0] shadow_slot [BUCKETS];
    int               shadow_count;

    rsp_word_t        pending_rsp_q [$];
    logic [KEY_W-1:0] stored_ids [$];
    dir_row_t         dir_table [DIR_ROWS];
    int               error_count;
    int               words_sent;
    int               words_checked;
    int               status_tally [5];

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Map behavior: updates the shadow table and returns the response word
    function automatic rsp_word_t predict_map(input logic [CMD_W-1:0] cmd,
                                              input logic [KEY_W-1:0] id);
        rsp_word_t   r;
        int unsigned pos;
        int unsigned n;
        bit          hit;
        bit          free_seen;
        r.status      = ST_ABSENT;
        r.slot_number = '0;
        if (cmd == CMD_CLEAR)
        begin
            for (n = 0; n < BUCKETS; n++)
                shadow_used[n] = 1'b0;
            shadow_count = 0;
            r.status = ST_FOUND;
        end
        else if (cmd == CMD_LOOKUP || cmd == CMD_INSERT)
        begin
            if (id == '0)
                r.status = ST_INVALID;
            else
            begin
                pos       = id % BUCKETS;
                hit       = 1'b0;
                free_seen = 1'b0;
                // linear probe, wrapping at the top bucket
                for (n = 0; n < BUCKETS && !hit && !free_seen; n++)
                begin
                    if (!shadow_used[pos])
                        free_seen = 1'b1;
                    else if (shadow_key[pos] == id)
                        hit = 1'b1;
                    else
                        pos = (pos + 1) % BUCKETS;
                end
                if (hit)
                begin
                    r.status      = ST_FOUND;
                    r.slot_number = shadow_slot[pos];
                end
                else if (cmd == CMD_LOOKUP)
                    r.status = ST_ABSENT;
                else if (!free_seen || (shadow_count + 1) * 4 > BUCKETS * 3)
                    r.status = ST_FULL;
                else
                begin
                    shadow_used[pos] = 1'b1;
                    shadow_key[pos]  = id;
                    shadow_slot[pos] = shadow_count[OUT_W-1:0];
                    r.slot_number    = shadow_count[OUT_W-1:0];
                    shadow_count++;
                    r.status = ST_INSERTED;
                end
            end
        end
        r.entry_count = shadow_count[OUT_W-1:0];
        return r;
    endfunction

    // Request driver: random gaps unless quiet, then hold the word until accepted
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] id,
                             input bit use_fixed, input rsp_word_t fixed);
        rsp_word_t predicted;
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                request_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        request_ch.valid   <= 1'b1;
        request_ch.command <= cmd;
        request_ch.type_id <= id;
        @(posedge clk);
        while (request_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = predict_map(cmd, id);
        pending_rsp_q.push_back(use_fixed ? fixed : predicted);
        status_tally[predicted.status]++;
        words_sent++;
        if (cmd == CMD_CLEAR)
            stored_ids.delete();
        else if (predicted.status == ST_INSERTED)
            stored_ids.push_back(id);
    endtask

    // Fresh identifier shaped by the phase's key pattern
    function automatic logic [KEY_W-1:0] pick_id(input int key_mode);
        logic [KEY_W-1:0] id;
        id = $urandom();
        if (key_mode == 1)
            id[7:0] = 8'hF8 | 8'($urandom_range(0, 7));     // crowd the top buckets
        else if (key_mode == 2)
            id = $urandom_range(1, 1023);
        return id;
    endfunction

    // Response sink: random stalls unless quiet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            response_ch.ready <= 1'b0;
        else
            response_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Response checker
    always @(posedge clk)
    begin
        rsp_word_t exp_rsp;
        if (rst_n && response_ch.valid === 1'b1 && response_ch.ready === 1'b1)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response word with nothing pending");
                error_count++;
            end
            else
            begin
                exp_rsp = pending_rsp_q.pop_front();
                words_checked++;
                if (response_ch.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status,
                           response_ch.status);
                    error_count++;
                end
                if (response_ch.slot_number !== exp_rsp.slot_number)
                begin
                    $error("slot_number: expected %0d, actual %0d", exp_rsp.slot_number,
                           response_ch.slot_number);
                    error_count++;
                end
                if (response_ch.entry_count !== exp_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
                           response_ch.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("linear_probe_id_map: mismatch");
        $finish;
    end

    // Stimulus
    initial
    begin
        int               phase;
        int               item;
        int               phase_len;
        int               key_mode;
        int               roll;
        int               ins_pct;
        int               old_pct;
        bit               fill;
        logic [KEY_W-1:0] id;
        logic [CMD_W-1:0] cmd;

        rst_n               = 1'b0;
        quiet               = 1'b0;
        request_ch.valid    = 1'b0;
        request_ch.command  = CMD_LOOKUP;
        request_ch.type_id  = '0;
        error_count         = 0;
        words_sent          = 0;
        words_checked       = 0;
        shadow_count        = 0;
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;
        foreach (status_tally[i])
            status_tally[i] = 0;

        // Directed rows; fixed answers where obvious, the rest predicted
        dir_table = '{
            '{CMD_LOOKUP, 32'h0000_0001, 1'b1, '{ST_ABSENT,   8'd0, 8'd0}},
            '{CMD_LOOKUP, 32'h0000_0000, 1'b1, '{ST_INVALID,  8'd0, 8'd0}},
            '{CMD_INSERT, 32'h0000_0000, 1'b1, '{ST_INVALID,  8'd0, 8'd0}},
            '{CMD_INSERT, 32'h0000_0001, 1'b1, '{ST_INSERTED, 8'd0, 8'd1}},
            '{CMD_INSERT, 32'h0000_0001, 1'b1, '{ST_FOUND,    8'd0, 8'd1}},
            '{CMD_LOOKUP, 32'h0000_0001, 1'b1, '{ST_FOUND,    8'd0, 8'd1}},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_INSERT, 32'h0000_01FF, 1'b0, '0},   // wraps to bucket 0
            '{CMD_INSERT, 32'h0000_0100, 1'b0, '0},   // walks past 0 and 1
            '{CMD_LOOKUP, 32'h0000_01FF, 1'b0, '0},
            '{CMD_LOOKUP, 32'h0000_0100, 1'b0, '0},
            '{CMD_LOOKUP, 32'h0000_0200, 1'b0, '0},   // absent after a chain
            '{CMD_INSERT, 32'h8000_0001, 1'b0, '0},
            '{CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_UNUSED, 32'h0000_0005, 1'b0, '0},
            '{CMD_UNUSED, 32'h0000_0000, 1'b0, '0},
            '{CMD_CLEAR,  32'hDEAD_BEEF, 1'b1, '{ST_FOUND,    8'd0, 8'd0}},
            '{CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{ST_ABSENT,   8'd0, 8'd0}},
            '{CMD_INSERT, 32'h8000_0000, 1'b1, '{ST_INSERTED, 8'd0, 8'd1}},
            '{CMD_CLEAR,  32'h0000_0000, 1'b1, '{ST_FOUND,    8'd0, 8'd0}},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_INSERTED, 8'd0, 8'd1}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_word(dir_table[i].cmd, dir_table[i].id, dir_table[i].has_fixed,
                      dir_table[i].fixed);

        // Random phases: each starts from an empty table
        for (phase = 0; phase < PHASES; phase++)
        begin
            fill      = (phase == 1 || phase == 5 || phase == 6);
            key_mode  = phase % 3;
            quiet     = (phase == 3);
            phase_len = fill ? 260 : 180;
            ins_pct   = fill ? 90 : 55;
            old_pct   = fill ? 95 : 75;
            send_word(CMD_CLEAR, $urandom(), 1'b0, '0);
            for (item = 1; item < phase_len; item++)
            begin
                roll = $urandom_range(0, 99);
                cmd  = CMD_LOOKUP;
                id   = pick_id(key_mode);
                if (roll == 0)
                    cmd = CMD_UNUSED;
                else if (roll == 1)
                begin
                    cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
                    id  = '0;
                end
                else if (roll == 2 && !fill)
                    cmd = CMD_CLEAR;
                else if (roll < ins_pct)
                    cmd = CMD_INSERT;
                else if (roll < old_pct)
                begin
                    cmd = CMD_INSERT;
                    if (stored_ids.size() != 0)
                        id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
                end
                else if ($urandom_range(0, 1) && stored_ids.size() != 0)
                    id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
                send_word(cmd, id, 1'b0, '0);
            end
        end
        quiet = 1'b0;
        request_ch.valid <= 1'b0;

        // Drain
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d request words, %0d response words checked",
                 words_sent, words_checked);
        $display("statuses: found %0d, inserted %0d, absent %0d, invalid %0d, full %0d",
                 status_tally[ST_FOUND], status_tally[ST_INSERTED],
                 status_tally[ST_ABSENT], status_tally[ST_INVALID],
                 status_tally[ST_FULL]);
        if (error_count == 0 && pending_rsp_q.size() == 0)
            $display("linear_probe_id_map: match");
        else
            $display("linear_probe_id_map: mismatch");
        $finish;
    end

endmodule
